@@ design/ppk_pkg.sv @@
// Package for the YUY2 payload packetiser: item, result and command types,
// configuration indexes, mode codes, header constants and sizes.
// No dependencies.
package ppk_pkg;

    // Sizes
    localparam int PALETTE_DEPTH   = 256;
    localparam int POSITION_BITS   = 20;
    localparam int PAL_AW          = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int PAL_WIDTH       = 24;
    localparam int FRAME_PAIRS_W   = 20;
    localparam int PAYLOAD_PAIRS_W = 8;
    localparam int CMP_W           = (POSITION_BITS > FRAME_PAIRS_W) ? POSITION_BITS
                                                                     : FRAME_PAIRS_W;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes and reset values
    localparam logic CFG_FRAME_PAIRS   = 1'b0;
    localparam logic CFG_PAYLOAD_PAIRS = 1'b1;
    localparam logic [FRAME_PAIRS_W-1:0]   FRAME_PAIRS_RST   = 20'd38400;
    localparam logic [PAYLOAD_PAIRS_W-1:0] PAYLOAD_PAIRS_RST = 8'd255;

    // Request modes
    localparam logic [1:0] MODE_PAL_WRITE = 2'd0;
    localparam logic [1:0] MODE_PAIR      = 2'd1;
    localparam logic [1:0] MODE_START     = 2'd2;
    localparam logic [1:0] MODE_ABORT     = 2'd3;

    // Packet header
    localparam logic [7:0] HEADER_LEN_BYTE = 8'h02;
    localparam int         HDR_FID_POS     = 0;
    localparam int         HDR_EOF_POS     = 1;

    // Byte steps of the output serialiser
    typedef enum logic [5:0] {
        STEP_LEN = 6'b000001,
        STEP_HDR = 6'b000010,
        STEP_Y0  = 6'b000100,
        STEP_U   = 6'b001000,
        STEP_Y1  = 6'b010000,
        STEP_V   = 6'b100000
    } step_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] palette_index;
        logic [7:0] pal_y;
        logic [7:0] pal_u;
        logic [7:0] pal_v;
        logic [7:0] gray_first;
        logic [7:0] gray_second;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_start;
        logic       packet_end;
        logic       frame_end;
        logic       last;
    } result_t;

    // One pixel pair, ready to be serialised
    typedef struct packed {
        logic       has_header;
        logic [7:0] header_byte;
        logic [7:0] y0;
        logic [7:0] u;
        logic [7:0] y1;
        logic [7:0] v;
        logic       pkt_end;
        logic       frm_end;
    } cmd_t;

    // Queue status seen by the top level and the serialiser
    typedef struct packed {
        logic                no_room;
        logic                head_valid;
    } queue_status_t;

endpackage

@@ design/palette_yuy2_payload_packetizer.sv @@
// Top level of the palette YUY2 payload packetiser.
// Holds the configuration registers; uses ppk_pkg, ppk_front, ppk_queue, ppk_back.
//
// Usage
//   Requests enter on item with push/full: palette writes, pixel pairs, frame
//   start and frame abort. Payload bytes leave on result with empty/pop; the
//   oldest byte is shown while empty is low. Configuration (frame_pairs at
//   index 0, payload_pairs at index 1) is written through cfg_valid/cfg_ready,
//   which is always ready; write it only while the block is idle.
//   Path: a pixel pair goes through the registered palette read, the command
//   queue and the serialiser's current-pair register before its first byte shows.
//   Throughput: a request can be taken every cycle while full is low; pixel
//   pairs are drained at one byte per cycle by the output serialiser while
//   pop is high, four bytes per pair, six for a pair that opens a packet.
//   A four-entry command queue sits between the palette lookup and the
//   serialiser; full rises when it and the pair in the palette read fill it up.
//   Reset clears frame state, frame id, queue and serialiser and loads the
//   register defaults; palette contents are undefined until written.
//   While pop stays low the current byte holds, the queue fills and full
//   rises; nothing is lost.
module palette_yuy2_payload_packetizer import ppk_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  item_t                    item,
    output logic                     empty,
    input  logic                     pop,
    output result_t                  result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [FRAME_PAIRS_W-1:0] cfg_data
);

    logic [FRAME_PAIRS_W-1:0]   frame_pairs_reg, frame_pairs_next;
    logic [PAYLOAD_PAIRS_W-1:0] payload_pairs_reg, payload_pairs_next;

    logic          accept;
    logic          cmd_valid;
    cmd_t          cmd;
    cmd_t          head;
    logic          head_take;
    queue_status_t q_status;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        frame_pairs_next   = frame_pairs_reg;
        payload_pairs_next = payload_pairs_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FRAME_PAIRS:   frame_pairs_next   = cfg_data;
                CFG_PAYLOAD_PAIRS: payload_pairs_next = cfg_data[PAYLOAD_PAIRS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pairs_reg   <= FRAME_PAIRS_RST;
            payload_pairs_reg <= PAYLOAD_PAIRS_RST;
        end
        else
        begin
            frame_pairs_reg   <= frame_pairs_next;
            payload_pairs_reg <= payload_pairs_next;
        end
    end

    // Request handshake
    assign full   = q_status.no_room;
    assign accept = push && !full;

    ppk_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .item          (item),
        .frame_pairs   (frame_pairs_reg),
        .payload_pairs (payload_pairs_reg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd)
    );

    ppk_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (cmd_valid),
        .wr_cmd    (cmd),
        .in_flight (cmd_valid),
        .rd        (head_take),
        .head      (head),
        .status    (q_status)
    );

    ppk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (q_status.head_valid),
        .head_take  (head_take),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

@@ design/ppk_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module ppk_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                      rdata_a,
    output logic [WIDTH-1:0]                      rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ design/ppk_front.sv @@
// Front end: takes requests, keeps frame and packet state, owns the palette
// RAM and builds one command per pixel pair. Uses ppk_pkg and ppk_ram.
module ppk_front import ppk_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  item_t                      item,
    input  logic [FRAME_PAIRS_W-1:0]   frame_pairs,
    input  logic [PAYLOAD_PAIRS_W-1:0] payload_pairs,
    output logic                       cmd_valid,
    output cmd_t                       cmd
);

    // Control state
    logic                     busy_reg, busy_next;
    logic                     fid_reg, fid_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [7:0]               pip_reg, pip_next;
    logic                     s1_valid_reg, s1_valid_next;

    // Stage one payload
    logic s1_hdr_reg, s1_eof_reg, s1_fid_reg, s1_pkt_end_reg, s1_frm_end_reg;
    logic s1_ok0_reg, s1_ok1_reg;

    logic                 pal_we;
    logic                 pal_index_ok, ok0, ok1;
    logic [PAL_WIDTH-1:0] rdata_a, rdata_b, c0, c1;
    logic [CMP_W-1:0]     pos_ext, fp_ext, left;
    logic [7:0]           limit;
    logic                 eof_hdr, frm_end, pkt_end;

    // Range checks on palette indexes
    assign pal_index_ok = 9'(item.palette_index) < 9'(PALETTE_DEPTH);
    assign ok0          = 9'(item.gray_first)    < 9'(PALETTE_DEPTH);
    assign ok1          = 9'(item.gray_second)   < 9'(PALETTE_DEPTH);

    // Position arithmetic for the pair being taken
    assign pos_ext = CMP_W'(pos_reg);
    assign fp_ext  = CMP_W'(frame_pairs);
    assign left    = fp_ext - pos_ext;
    assign limit   = (payload_pairs == '0) ? 8'd1 : payload_pairs;
    assign eof_hdr = left <= CMP_W'(limit);
    assign frm_end = left == CMP_W'(1);
    assign pkt_end = frm_end || ((9'(pip_reg) + 9'd1) >= 9'(limit));

    // Request decode and state update
    always_comb
    begin
        busy_next     = busy_reg;
        fid_next      = fid_reg;
        pos_next      = pos_reg;
        pip_next      = pip_reg;
        s1_valid_next = 1'b0;
        pal_we        = 1'b0;
        if (accept)
        begin
            case (item.mode)
                MODE_PAL_WRITE:
                begin
                    pal_we = pal_index_ok;
                end
                MODE_PAIR:
                begin
                    if (busy_reg)
                    begin
                        if (pos_ext >= fp_ext)
                        begin
                            busy_next = 1'b0;
                            pos_next  = '0;
                            pip_next  = '0;
                        end
                        else
                        begin
                            s1_valid_next = 1'b1;
                            if (frm_end)
                            begin
                                busy_next = 1'b0;
                                pos_next  = '0;
                                pip_next  = '0;
                            end
                            else
                            begin
                                pos_next = pos_reg + POSITION_BITS'(1);
                                pip_next = pkt_end ? 8'd0 : pip_reg + 8'd1;
                            end
                        end
                    end
                end
                MODE_START:
                begin
                    if (!busy_reg && (frame_pairs != '0))
                    begin
                        busy_next = 1'b1;
                        fid_next  = ~fid_reg;
                        pos_next  = '0;
                        pip_next  = '0;
                    end
                end
                MODE_ABORT:
                begin
                    busy_next = 1'b0;
                    pos_next  = '0;
                    pip_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            fid_reg      <= 1'b0;
            pos_reg      <= '0;
            pip_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            fid_reg      <= fid_next;
            pos_reg      <= pos_next;
            pip_reg      <= pip_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage one flags, held alongside the palette read
    always_ff @(posedge clk)
    begin
        s1_hdr_reg     <= pip_reg == '0;
        s1_eof_reg     <= eof_hdr;
        s1_fid_reg     <= fid_reg;
        s1_pkt_end_reg <= pkt_end;
        s1_frm_end_reg <= frm_end;
        s1_ok0_reg     <= ok0;
        s1_ok1_reg     <= ok1;
    end

    // Palette lookup
    ppk_ram #(
        .WIDTH (PAL_WIDTH),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .we      (pal_we),
        .waddr   (item.palette_index[PAL_AW-1:0]),
        .wdata   ({item.pal_y, item.pal_u, item.pal_v}),
        .raddr_a (item.gray_first[PAL_AW-1:0]),
        .raddr_b (item.gray_second[PAL_AW-1:0]),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Build the pair command: luma bytes and rounded-down chroma means
    assign c0 = s1_ok0_reg ? rdata_a : '0;
    assign c1 = s1_ok1_reg ? rdata_b : '0;

    always_comb
    begin
        cmd                          = '0;
        cmd.has_header               = s1_hdr_reg;
        cmd.header_byte[HDR_FID_POS] = s1_fid_reg;
        cmd.header_byte[HDR_EOF_POS] = s1_eof_reg;
        cmd.y0                       = c0[23:16];
        cmd.u                        = 8'((9'(c0[15:8]) + 9'(c1[15:8])) >> 1);
        cmd.y1                       = c1[23:16];
        cmd.v                        = 8'((9'(c0[7:0]) + 9'(c1[7:0])) >> 1);
        cmd.pkt_end                  = s1_pkt_end_reg;
        cmd.frm_end                  = s1_frm_end_reg;
    end

    assign cmd_valid = s1_valid_reg;

endmodule

@@ design/ppk_queue.sv @@
// Short command queue between front end and serialiser; reports room
// including the pair still in the palette read. Uses ppk_pkg.
module ppk_queue import ppk_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  cmd_t          wr_cmd,
    input  logic          in_flight,
    input  logic          rd,
    output cmd_t          head,
    output queue_status_t status
);

    cmd_t                entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                                                              : wr_ptr_reg + QUEUE_AW'(1);
        end
        if (rd)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                                                              : rd_ptr_reg + QUEUE_AW'(1);
        end
        if (wr && !rd)
        begin
            count_next = count_reg + QUEUE_CW'(1);
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entries[wr_ptr_reg] <= wr_cmd;
        end
    end

    assign head              = entries[rd_ptr_reg];
    assign status.head_valid = count_reg != '0;
    assign status.no_room    = (32'(count_reg) + 32'(in_flight)) >= QUEUE_DEPTH;

endmodule

@@ design/ppk_back.sv @@
// Back end: serialises one pair command into optional header and YUY2 bytes and
// presents them as a queue head. Uses ppk_pkg.
module ppk_back import ppk_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    head,
    input  logic    head_valid,
    output logic    head_take,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    logic       cur_valid_reg, cur_valid_next;
    step_t      step_reg, step_next;
    cmd_t       cur_reg;
    logic       consume, done, load;

    assign consume   = pop && cur_valid_reg;
    assign done      = consume && (step_reg == STEP_V);
    assign load      = !cur_valid_reg || done;
    assign head_take = load && head_valid;

    // Step sequencing
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (head_take)
        begin
            cur_valid_next = 1'b1;
            step_next      = head.has_header ? STEP_LEN : STEP_Y0;
        end
        else if (done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (consume)
        begin
            case (step_reg)
                STEP_LEN: step_next = STEP_HDR;
                STEP_HDR: step_next = STEP_Y0;
                STEP_Y0:  step_next = STEP_U;
                STEP_U:   step_next = STEP_Y1;
                STEP_Y1:  step_next = STEP_V;
                default:  step_next = step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= STEP_LEN;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_take)
        begin
            cur_reg <= head;
        end
    end

    // Byte select for the current step
    always_comb
    begin
        result = '0;
        case (step_reg)
            STEP_LEN:
            begin
                result.out_byte     = HEADER_LEN_BYTE;
                result.packet_start = 1'b1;
            end
            STEP_HDR: result.out_byte = cur_reg.header_byte;
            STEP_Y0:  result.out_byte = cur_reg.y0;
            STEP_U:   result.out_byte = cur_reg.u;
            STEP_Y1:  result.out_byte = cur_reg.y1;
            STEP_V:
            begin
                result.out_byte   = cur_reg.v;
                result.packet_end = cur_reg.pkt_end;
                result.frame_end  = cur_reg.frm_end;
                result.last       = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign empty = !cur_valid_reg;

endmodule

@@ tb/sv/palette_yuy2_payload_packetizer_tb.sv @@
// Self-checking testbench for the palette YUY2 payload packetiser.
// A directed table walk is followed by random frames, checked byte by byte
// against an in-bench predictor. Depends on ppk_pkg and palette_yuy2_payload_packetizer.
module palette_yuy2_payload_packetizer_tb;
    import ppk_pkg::*;

    // Row kinds of the directed table
    localparam logic [1:0] ROW_CFG   = 2'd0;
    localparam logic [1:0] ROW_REQ   = 2'd1;
    localparam logic [1:0] ROW_TYPED = 2'd2;

    localparam int N_DIRECTED  = 34;
    localparam int RANDOM_REQS = 90;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        logic [1:0]               kind;
        logic                     cfg_idx;
        logic [FRAME_PAIRS_W-1:0] cfg_val;
        item_t                    req;
        logic [2:0]               n_exp;
        logic [47:0]              exp_bytes;  // first byte in the top byte
        logic                     exp_pe;
        logic                     exp_fe;
    } stim_row_t;

    localparam item_t       NO_REQ   = '0;
    localparam logic [47:0] NO_BYTES = '0;

    logic                     clk;
    logic                     rst_n;
    logic                     push;
    logic                     full;
    item_t                    item;
    logic                     empty;
    logic                     pop;
    result_t                  result;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic                     cfg_index;
    logic [FRAME_PAIRS_W-1:0] cfg_data;

    palette_yuy2_payload_packetizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state
    logic [PAL_WIDTH-1:0]       pal_ram [PALETTE_DEPTH];
    logic [7:0]                 known_grays [$];
    bit                         frame_open        = 1'b0;
    bit                         fid               = 1'b0;
    logic [POSITION_BITS-1:0]   pairs_sent        = '0;
    logic [7:0]                 pairs_in_pkt      = '0;
    logic [FRAME_PAIRS_W-1:0]   cfg_frame_pairs   = FRAME_PAIRS_RST;
    logic [PAYLOAD_PAIRS_W-1:0] cfg_payload_pairs = PAYLOAD_PAIRS_RST;
    result_t                    pred_out [6];
    int                         pred_n;
    result_t                    payload_fifo [$];

    // Bookkeeping
    int errors         = 0;
    int requests_taken = 0;
    int effective_reqs = 0;
    int bytes_taken    = 0;
    int frames_seen    = 0;
    int cfg_writes     = 0;
    bit stall_drain    = 1'b0;

    // Clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on run time
    initial begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        begin
            errors++;
            if (errors <= PRINT_CAP)
                $display("MISMATCH byte %0d: %s", bytes_taken, what);
        end
    endtask

    function automatic void add_pred(input logic [7:0] b, input bit ps, input bit pe,
                                     input bit fe);
        pred_out[pred_n] = '{b, ps, pe, fe, 1'b0};
        pred_n++;
    endfunction

    // Work out the payload bytes one request produces and move the state on
    task automatic packetize_request(input item_t req);
        int unsigned     left;
        int unsigned     limit;
        logic [23:0]     c0;
        logic [23:0]     c1;
        logic [8:0]      u_sum;
        logic [8:0]      v_sum;
        logic [7:0]      hdr;
        bit              pe;
        bit              fe;
        begin
            pred_n = 0;
            case (req.mode)
                MODE_PAL_WRITE: begin
                    pal_ram[req.palette_index] = {req.pal_y, req.pal_u, req.pal_v};
                    known_grays.push_back(req.palette_index);
                    effective_reqs++;
                end
                MODE_START: begin
                    if (!frame_open && cfg_frame_pairs != '0) begin
                        frame_open   = 1'b1;
                        fid          = ~fid;
                        pairs_sent   = '0;
                        pairs_in_pkt = '0;
                        effective_reqs++;
                    end
                end
                MODE_ABORT: begin
                    frame_open   = 1'b0;
                    pairs_sent   = '0;
                    pairs_in_pkt = '0;
                    effective_reqs++;
                end
                default: begin
                    if (frame_open && pairs_sent >= cfg_frame_pairs) begin
                        // frame shortened under a running frame: close it, drop the pair
                        frame_open   = 1'b0;
                        pairs_sent   = '0;
                        pairs_in_pkt = '0;
                    end else if (frame_open) begin
                        left  = cfg_frame_pairs - pairs_sent;
                        limit = (cfg_payload_pairs == '0) ? 1 : cfg_payload_pairs;
                        if (pairs_in_pkt == '0) begin
                            hdr              = '0;
                            hdr[HDR_FID_POS] = fid;
                            hdr[HDR_EOF_POS] = (left <= limit);
                            add_pred(HEADER_LEN_BYTE, 1'b1, 1'b0, 1'b0);
                            add_pred(hdr, 1'b0, 1'b0, 1'b0);
                        end
                        c0    = pal_ram[req.gray_first];
                        c1    = pal_ram[req.gray_second];
                        u_sum = c0[15:8] + c1[15:8];
                        v_sum = c0[7:0] + c1[7:0];
                        fe    = (left == 1);
                        pe    = fe || (pairs_in_pkt + 1 >= limit);
                        add_pred(c0[23:16], 1'b0, 1'b0, 1'b0);
                        add_pred(u_sum[8:1], 1'b0, 1'b0, 1'b0);
                        add_pred(c1[23:16], 1'b0, 1'b0, 1'b0);
                        add_pred(v_sum[8:1], 1'b0, pe, fe);
                        pred_out[pred_n-1].last = 1'b1;
                        if (fe) begin
                            frame_open   = 1'b0;
                            pairs_sent   = '0;
                            pairs_in_pkt = '0;
                        end else begin
                            pairs_sent   = pairs_sent + 1'b1;
                            pairs_in_pkt = pe ? 8'd0 : pairs_in_pkt + 8'd1;
                        end
                        effective_reqs++;
                    end
                end
            endcase
        end
    endtask

    // Random request of one mode; pairs only look up written palette entries
    function automatic item_t random_request(input logic [1:0] mode);
        logic [63:0] raw;
        item_t       req;
        begin
            raw      = {$urandom(), $urandom()};
            req      = raw[$bits(item_t)-1:0];
            req.mode = mode;
            if (mode == MODE_PAIR) begin
                req.gray_first  = known_grays[$urandom_range(known_grays.size() - 1)];
                req.gray_second = known_grays[$urandom_range(known_grays.size() - 1)];
            end
            return req;
        end
    endfunction

    // Offer one request; called and returns at a falling edge
    task automatic offer_request(input stim_row_t row);
        result_t want;
        int      k;
        begin
            while (!(effective_reqs >= 60 && effective_reqs < 95) &&
                   $urandom_range(99) < 34) begin
                push <= 1'b0;
                @(negedge clk);
            end
            item <= row.req;
            push <= 1'b1;
            @(posedge clk);
            while (full) @(posedge clk);
            requests_taken++;
            packetize_request(row.req);
            if (row.kind == ROW_TYPED) begin
                for (k = 0; k < row.n_exp; k++) begin
                    want.out_byte     = row.exp_bytes[47 - 8*k -: 8];
                    want.packet_start = (k == 0) && (row.n_exp == 3'd6);
                    want.packet_end   = (k == row.n_exp - 1) && row.exp_pe;
                    want.frame_end    = (k == row.n_exp - 1) && row.exp_fe;
                    want.last         = (k == row.n_exp - 1);
                    payload_fifo.push_back(want);
                end
            end else begin
                for (k = 0; k < pred_n; k++)
                    payload_fifo.push_back(pred_out[k]);
            end
            @(negedge clk);
        end
    endtask

    // Register write; called and returns at a falling edge
    task automatic write_reg(input logic idx, input logic [FRAME_PAIRS_W-1:0] val);
        begin
            cfg_index <= idx;
            cfg_data  <= val;
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            if (idx == CFG_FRAME_PAIRS)
                cfg_frame_pairs = val;
            else
                cfg_payload_pairs = val[PAYLOAD_PAIRS_W-1:0];
            cfg_writes++;
            @(negedge clk);
            cfg_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Stop sending and let the block run dry, including requests with no bytes
    task automatic wait_drained();
        begin
            push <= 1'b0;
            while (payload_fifo.size() != 0) @(negedge clk);
            repeat (8) @(negedge clk);
        end
    endtask

    // Compare one taken byte with the oldest expectation
    task automatic check_byte(input result_t got);
        result_t want;
        begin
            bytes_taken++;
            if (got.frame_end === 1'b1)
                frames_seen++;
            if (payload_fifo.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", got.out_byte));
            end else begin
                want = payload_fifo.pop_front();
                if (got.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              got.out_byte, want.out_byte));
                if (got.packet_start !== want.packet_start)
                    report_mismatch($sformatf("packet_start %b, want %b",
                                              got.packet_start, want.packet_start));
                if (got.packet_end !== want.packet_end)
                    report_mismatch($sformatf("packet_end %b, want %b",
                                              got.packet_end, want.packet_end));
                if (got.frame_end !== want.frame_end)
                    report_mismatch($sformatf("frame_end %b, want %b",
                                              got.frame_end, want.frame_end));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", got.last, want.last));
            end
        end
    endtask

    // Receiver: random pop, one long hold-off on request, a stretch with no gaps
    initial begin : drain
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        pop <= 1'b0;
        forever begin
            @(negedge clk);
            if (stall_drain && !hold_done) begin
                hold_left = 80;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (bytes_taken >= 200 && bytes_taken < 320) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(99) >= 34);
            end
            @(posedge clk);
            if (pop && !empty)
                check_byte(result);
        end
    end

    // Directed table: after reset, header bits, rounding, every mode and corner
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_CFG, CFG_FRAME_PAIRS, 20'd3, NO_REQ, 3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_CFG, CFG_PAYLOAD_PAIRS, 20'd2, NO_REQ, 3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_TYPED, 1'b0, 20'd0, '{MODE_PAL_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_TYPED, 1'b0, 20'd0, '{MODE_PAL_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_PAL_WRITE, 8'h5A, 8'h81, 8'h7E, 8'h33, 8'h00, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        // pair with no frame running is dropped
        '{ROW_TYPED, 1'b0, 20'd0, '{MODE_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_TYPED, 1'b0, 20'd0, '{MODE_ABORT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        // second start while busy: ignored
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_TYPED, 1'b0, 20'd0, '{MODE_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF},
          3'd6, 48'h02_01_00_7F_FF_7F, 1'b0, 1'b0},
        '{ROW_TYPED, 1'b0, 20'd0, '{MODE_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF},
          3'd4, 48'hFF_FF_FF_FF_00_00, 1'b1, 1'b0},
        // last pair of the frame: end-of-frame header bit set
        '{ROW_TYPED, 1'b0, 20'd0, '{MODE_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          3'd6, 48'h02_03_00_00_00_00, 1'b1, 1'b1},
        '{ROW_TYPED, 1'b0, 20'd0, '{MODE_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A, 8'h5A},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        // abort in mid frame keeps the frame id
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_ABORT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_CFG, CFG_FRAME_PAIRS, 20'd0, NO_REQ, 3'd0, NO_BYTES, 1'b0, 1'b0},
        // zero-length frame: start ignored, pair dropped
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_TYPED, 1'b0, 20'd0, '{MODE_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_CFG, CFG_FRAME_PAIRS, 20'hFFFFF, NO_REQ, 3'd0, NO_BYTES, 1'b0, 1'b0},
        // zero payload size means one pair per packet
        '{ROW_CFG, CFG_PAYLOAD_PAIRS, 20'd0, NO_REQ, 3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h5A},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_CFG, CFG_PAYLOAD_PAIRS, 20'd255, NO_REQ, 3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A, 8'hFF},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        // payload size lowered inside an open packet: packet closes on the next pair
        '{ROW_CFG, CFG_PAYLOAD_PAIRS, 20'd1, NO_REQ, 3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        // frame length lowered below the pairs already sent: frame dropped
        '{ROW_CFG, CFG_FRAME_PAIRS, 20'd2, NO_REQ, 3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          3'd0, NO_BYTES, 1'b0, 1'b0},
        '{ROW_REQ, 1'b0, 20'd0, '{MODE_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A, 8'hFF},
          3'd0, NO_BYTES, 1'b0, 1'b0}
    };

    // Main sequence
    initial begin : stimulus
        stim_row_t                row;
        logic [FRAME_PAIRS_W-1:0] choice;
        int                       target;
        int                       phase;
        int                       n_pairs;
        int                       r;
        int                       k;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_FRAME_PAIRS;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
            end else begin
                offer_request(directed_rows[i]);
            end
        end

        // Random frames, one setting per phase
        target = requests_taken + RANDOM_REQS;
        phase  = 0;
        row    = '0;
        row.kind = ROW_REQ;
        while (requests_taken < target) begin
            wait_drained();
            if (phase == 2) begin
                // pressure phase: long frame while the receiver holds off
                write_reg(CFG_FRAME_PAIRS, 20'd40);
                write_reg(CFG_PAYLOAD_PAIRS, 20'd6);
                row.req = random_request(MODE_ABORT);
                offer_request(row);
                stall_drain = 1'b1;
                n_pairs = 30;
            end else begin
                if ($urandom_range(99) < 60) begin
                    r = $urandom_range(99);
                    if (r < 70)      choice = $urandom_range(1, 8);
                    else if (r < 85) choice = $urandom_range(9, 30);
                    else if (r < 90) choice = '0;
                    else if (r < 95) choice = 20'hFFFFF;
                    else             choice = $urandom_range(1, 20'hFFFFF);
                    write_reg(CFG_FRAME_PAIRS, choice);
                end
                if ($urandom_range(99) < 60) begin
                    r = $urandom_range(99);
                    if (r < 70)      choice = $urandom_range(1, 4);
                    else if (r < 80) choice = '0;
                    else if (r < 90) choice = 20'd255;
                    else             choice = $urandom_range(1, 255);
                    write_reg(CFG_PAYLOAD_PAIRS, choice);
                end
                n_pairs = ((cfg_frame_pairs > 10) ? 10 : cfg_frame_pairs) + $urandom_range(2);
            end
            repeat ($urandom_range(2)) begin
                row.req = random_request(MODE_PAL_WRITE);
                offer_request(row);
            end
            row.req = random_request(MODE_START);
            offer_request(row);
            for (k = 0; k < n_pairs; k++) begin
                r = $urandom_range(99);
                if (r < 4 && phase != 2)
                    row.req = random_request(MODE_ABORT);
                else if (r < 12)
                    row.req = random_request($urandom_range(3));
                else
                    row.req = random_request(MODE_PAIR);
                offer_request(row);
            end
            phase++;
        end

        // Drain with a bound, then a short tail for stray bytes
        push <= 1'b0;
        for (k = 0; k < 20000 && payload_fifo.size() != 0; k++) @(negedge clk);
        repeat (20) @(negedge clk);
        if (payload_fifo.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never came", payload_fifo.size()));

        $display("Run: %0d requests, %0d register writes, %0d random phases.",
                 requests_taken, cfg_writes, phase);
        $display("Checked %0d payload bytes over %0d closed frames, %0d mismatches.",
                 bytes_taken, frames_seen, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
